FILE: hdl/sitda_pkg.sv
// Shared widths, state type, character and digit constants for the signed integer to decimal text converter.
package sitda_pkg;

  localparam int CODE_BITS  = 6;
  localparam int DIGIT_BITS = 4;

  localparam logic [CODE_BITS-1:0] CHAR_ZERO  = 6'd48;
  localparam logic [CODE_BITS-1:0] CHAR_MINUS = 6'd45;

  localparam logic [DIGIT_BITS-1:0] RADIX      = 4'd10;
  localparam logic [DIGIT_BITS-1:0] DIGIT_FIX  = 4'd3;
  localparam logic [DIGIT_BITS-1:0] DIGIT_HALF = 4'd5;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_CONV = 4'b0010,
    S_SKIP = 4'b0100,
    S_EMIT = 4'b1000
  } state_t;

endpackage

FILE: hdl/signed_int_to_decimal_ascii.sv
// Signed integer to decimal ASCII character stream, bit-serial double dabble.
//
// Input channel: value with in_valid / in_ready. One signed integer per transfer.
// Output channel: ascii_code and last_char with out_valid / out_ready, one character
// per transfer, most significant first, minus sign first for negative values, no
// leading zeros, last_char set on the final character.
// Operation: load the value, then VALUE_BITS steps of shift-and-correct conversion
// (one magnitude bit per cycle through the BCD shift register), then the leading
// zeros are shifted out one by one and the zero skip is left, then one character per
// cycle while out_ready is high.
// The conversion shift takes up most of an item's time.
// in_ready is high only between items; the next value is taken while the final
// character still waits in the output register.
// A stalled receiver holds the output register and stalls the characters after it.
// Reset empties the output register and returns the block to waiting for input.
module signed_int_to_decimal_ascii #(
  parameter int VALUE_BITS = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [VALUE_BITS-1:0]           value,
  input  logic                            in_valid,
  output logic                            in_ready,
  output logic [sitda_pkg::CODE_BITS-1:0] ascii_code,
  output logic                            last_char,
  output logic                            out_valid,
  input  logic                            out_ready
);
  import sitda_pkg::*;

  localparam int NDIG = (VALUE_BITS * 1233) / 4096 + 1;
  localparam int BCDW = NDIG * DIGIT_BITS;
  localparam int BCW  = $clog2(VALUE_BITS);
  localparam int DCW  = $clog2(NDIG + 1);

  state_t                  state;
  logic [VALUE_BITS-1:0]   mag;
  logic [BCDW-1:0]         bcd;
  logic [BCDW-1:0]         bcd_fix;
  logic [BCW-1:0]          bitcnt;
  logic [DCW-1:0]          digcnt;
  logic                    neg;
  logic [DIGIT_BITS-1:0]   top_digit;
  logic                    out_load;
  logic                    emit;
  logic [VALUE_BITS-1:0]   mag_next;

  assign in_ready  = (state == S_IDLE);
  assign top_digit = bcd[BCDW-1 -: DIGIT_BITS];
  assign out_load  = !out_valid || out_ready;
  assign emit      = (state == S_EMIT) && out_load;
  assign mag_next  = value[VALUE_BITS-1] ? (~value + 1'b1) : value;

  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      if (bcd[i*DIGIT_BITS +: DIGIT_BITS] >= DIGIT_HALF) begin
        bcd_fix[i*DIGIT_BITS +: DIGIT_BITS] = bcd[i*DIGIT_BITS +: DIGIT_BITS] + DIGIT_FIX;
      end else begin
        bcd_fix[i*DIGIT_BITS +: DIGIT_BITS] = bcd[i*DIGIT_BITS +: DIGIT_BITS];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            mag    <= mag_next;
            neg    <= value[VALUE_BITS-1];
            bcd    <= '0;
            bitcnt <= BCW'(VALUE_BITS - 1);
            state  <= S_CONV;
          end
        end
        S_CONV: begin
          bcd <= {bcd_fix[BCDW-2:0], mag[VALUE_BITS-1]};
          mag <= {mag[VALUE_BITS-2:0], 1'b0};
          if (bitcnt == '0) begin
            digcnt <= DCW'(NDIG);
            state  <= S_SKIP;
          end else begin
            bitcnt <= bitcnt - 1'b1;
          end
        end
        S_SKIP: begin
          if (top_digit == '0 && digcnt != DCW'(1)) begin
            bcd    <= {bcd[BCDW-DIGIT_BITS-1:0], {DIGIT_BITS{1'b0}}};
            digcnt <= digcnt - 1'b1;
          end else begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_load) begin
            if (neg) begin
              ascii_code <= CHAR_MINUS;
              last_char  <= 1'b0;
              neg        <= 1'b0;
            end else begin
              ascii_code <= CHAR_ZERO + CODE_BITS'(top_digit);
              last_char  <= (digcnt == DCW'(1));
              bcd        <= {bcd[BCDW-DIGIT_BITS-1:0], {DIGIT_BITS{1'b0}}};
              digcnt     <= digcnt - 1'b1;
              if (digcnt == DCW'(1)) begin
                state <= S_IDLE;
              end
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_code_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (ascii_code == CHAR_MINUS) ||
                  (ascii_code >= CHAR_ZERO && ascii_code < CHAR_ZERO + CODE_BITS'(RADIX)))
    else $error("character code out of range");

  a_minus_not_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && ascii_code == CHAR_MINUS) |-> !last_char)
    else $error("minus sign flagged as last character");

  a_digits_left: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT || state == S_SKIP) |-> digcnt != '0)
    else $error("digit count ran out before the end of the text");

  a_start_conv: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> state == S_CONV)
    else $error("accepted value did not start conversion");

endmodule

FILE: dv/sitda_checker.sv
// Checker for the decimal text converter: predicts each value's characters and compares.
`timescale 1ns / 1ps

module sitda_checker #(
  parameter int VALUE_BITS = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [VALUE_BITS-1:0]           value,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  logic [sitda_pkg::CODE_BITS-1:0] ascii_code,
  input  logic                            last_char,
  input  logic                            out_valid,
  input  logic                            out_ready,
  output int                              errors,
  output int                              pending
);
  import sitda_pkg::*;

  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [CODE_BITS-1:0] code;
    logic                 last;
  } text_char_t;

  text_char_t text_chars [$];

  function automatic void expand_decimal(input logic [VALUE_BITS-1:0] v);
    logic [VALUE_BITS-1:0] mag;
    logic [DIGIT_BITS-1:0] digit_buf [$];
    logic [DIGIT_BITS-1:0] d;
    text_char_t            c;
    logic                  neg;
    neg = v[VALUE_BITS-1];
    // unsigned negate, so the most negative value comes out right
    mag = neg ? (~v + 1'b1) : v;
    do begin
      digit_buf.push_back(DIGIT_BITS'(mag % 10));
      mag = mag / 10;
    end while (mag != 0);
    if (neg) begin
      c.code = CHAR_MINUS;
      c.last = 1'b0;
      text_chars.push_back(c);
    end
    while (digit_buf.size() > 0) begin
      d = digit_buf.pop_back();
      c.code = CHAR_ZERO + CODE_BITS'(d);
      c.last = (digit_buf.size() == 0);
      text_chars.push_back(c);
    end
  endfunction

  always @(posedge clk) begin
    text_char_t want;
    if (!rst) begin
      if (in_valid && in_ready) begin
        expand_decimal(value);
      end
      if (out_valid && out_ready) begin
        if (text_chars.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS) begin
            $display("%0t: unexpected character transfer: code %0d last %0b",
                     $realtime, ascii_code, last_char);
          end
        end else begin
          want = text_chars.pop_front();
          if (want.code !== ascii_code || want.last !== last_char) begin
            errors++;
            if (errors <= MAX_REPORTS) begin
              $display("%0t: mismatch: expected code %0d last %0b, got code %0d last %0b",
                       $realtime, want.code, want.last, ascii_code, last_char);
            end
          end
        end
      end
      pending = text_chars.size();
    end
  end

endmodule

FILE: dv/testbench.sv
// Top-level testbench for the decimal text converter: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module testbench;
  import sitda_pkg::*;

  localparam int VALUE_BITS   = 32;
  localparam int RANDOM_ITEMS = 310;
  localparam int QUIET_ITEMS  = 40;
  localparam int HOLD_ITEM    = 60;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 64;

  logic                  clk;
  logic                  rst;
  logic [VALUE_BITS-1:0] value;
  logic                  in_valid;
  logic                  in_ready;
  logic [CODE_BITS-1:0]  ascii_code;
  logic                  last_char;
  logic                  out_valid;
  logic                  out_ready;
  int                    errors;
  int                    pending;
  bit                    quiet;
  bit                    hold_req;
  bit                    hold_done;

  logic [31:0] directed_vals [] = '{
    32'd0, 32'd1, 32'hFFFF_FFFF, 32'd9, 32'd10, -32'sd10, 32'd99, 32'd100,
    32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001, 32'd1000000000,
    32'd999999999, -32'sd999999999, 32'd1234567890, -32'sd1234567890,
    32'd7, -32'sd5, 32'h5555_5555, 32'hAAAA_AAAA, -32'sd1000000000
  };

  initial clk = 1'b0;
  always #5 clk = ~clk;

  signed_int_to_decimal_ascii #(
    .VALUE_BITS(VALUE_BITS)
  ) u_dut (
    .clk       (clk),
    .rst       (rst),
    .value     (value),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .ascii_code(ascii_code),
    .last_char (last_char),
    .out_valid (out_valid),
    .out_ready (out_ready)
  );

  sitda_checker #(
    .VALUE_BITS(VALUE_BITS)
  ) u_checker (
    .clk       (clk),
    .rst       (rst),
    .value     (value),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .ascii_code(ascii_code),
    .last_char (last_char),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .errors    (errors),
    .pending   (pending)
  );

  function automatic longint pow10(input int n);
    longint p;
    p = 1;
    repeat (n) p = p * 10;
    return p;
  endfunction

  function automatic logic [31:0] pick_value();
    longint lo;
    longint hi;
    longint v;
    int     d;
    int     off;
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        v = longint'($urandom);
      end
      3, 4, 5, 6, 7: begin
        d  = $urandom_range(1, 10);
        lo = (d == 1) ? 0 : pow10(d - 1);
        hi = (d == 10) ? 64'd2147483647 : pow10(d) - 1;
        v  = lo + longint'($urandom) % (hi - lo + 1);
        if ($urandom_range(0, 1)) v = -v;
      end
      8: begin
        off = $urandom_range(0, 2);
        v   = pow10($urandom_range(0, 9)) + off - 1;
        if ($urandom_range(0, 1)) v = -v;
      end
      default: begin
        case ($urandom_range(0, 3))
          0: v = 64'd2147483647;
          1: v = -64'sd2147483648;
          2: v = -64'sd2147483647;
          default: v = 0;
        endcase
      end
    endcase
    return v[31:0];
  endfunction

  task automatic send_value(input logic [31:0] v, input bit allow_gap);
    int gap;
    if (allow_gap && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 8);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    value    <= v;
    do @(posedge clk); while (!in_ready);
  endtask

  initial begin
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    value     <= '0;
    quiet     = 1'b0;
    hold_req  = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    foreach (directed_vals[i]) send_value(directed_vals[i], 1'b1);
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == HOLD_ITEM) hold_req = 1'b1;
      if (i == RANDOM_ITEMS - QUIET_ITEMS) quiet = 1'b1;
      send_value(pick_value(), !quiet);
    end
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("PASS signed_int_to_decimal_ascii");
    end else begin
      $display("FAIL signed_int_to_decimal_ascii");
    end
    $finish;
  end

  // receiver: random stalls, occasional steady stretches, one long hold-off
  initial begin
    out_ready <= 1'b0;
    hold_done = 1'b0;
    wait (rst === 1'b0);
    @(posedge clk);
    forever begin
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end else if (!quiet && $urandom_range(0, 39) == 0) begin
        out_ready <= 1'b1;
        repeat (40) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  initial begin
    #5_000_000;
    $display("FAIL signed_int_to_decimal_ascii");
    $finish;
  end

endmodule
